// ===== rtl/trapezoidal_velocity_step_core_defines.svh =====
// Assertion macros shared by the trapezoidal velocity step block.
// No dependencies; included by the top level only.
`ifndef TRAPEZOIDAL_VELOCITY_STEP_CORE_DEFINES_SVH
`define TRAPEZOIDAL_VELOCITY_STEP_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define TVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tvs_pkg.sv =====
// Package for the trapezoidal velocity step block: payload types, sequencer
// states, register indexes and shared constants. No dependencies.
package tvs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 31;

  localparam logic [CFG_IDX_W-1:0] REG_FINAL_VEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_CAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd4;

  localparam logic [1:0] PH_DONE  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_CONST = 2'd2;
  localparam logic [1:0] PH_DECEL = 2'd3;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0] dist_left;
    logic        new_move;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] increment;
    logic signed [31:0] new_velocity;
    logic signed [31:0] accel_out;
    logic [1:0]         phase;
  } out_item_t;

  // sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TICKS,     // ticks = diff / accel
    ST_M_DC,      // diff * cycle
    ST_M_STOP,    // half(.) * ticks
    ST_M_WIN,     // half(fv + accel) * cycle
    ST_M_AC,      // accel * cycle
    ST_DECIDE,
    ST_DEC_INC,   // half(nv + v) * cycle
    ST_DEC_CHK,
    ST_DEC_HV,    // half(v) * cycle
    ST_DEC_DIV,   // 2*rest / cycle
    ST_ACC_INC,   // half(|nv + v|) * cycle
    ST_ACC_OUT,   // (nv - v) / cycle
    ST_OUT
  } seq_state_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic               start;
    logic               is_div;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } alu_rsp_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x > 33'sd2147483647) return SMAX;
    if (x < -33'sd2147483648) return SMIN;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] half32(input logic signed [31:0] x);
    logic signed [31:0] r;
    r = x >>> 1;
    if (x[31] && x[0]) r = r + 32'sd1;
    return r;
  endfunction

endpackage

// ===== rtl/tvs_alu.sv =====
// Shared fixed-point multiply/divide unit: shift-add multiply and
// restoring divide, one bit per cycle, with saturation. Uses tvs_pkg.
module tvs_alu #(
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tvs_pkg::alu_req_t req,
  output tvs_pkg::alu_rsp_t rsp
);
  import tvs_pkg::*;

  localparam int MW = 32 + FRAC_BITS;  // divider dividend width
  localparam int CW = 7;

  logic            busy_r, busy_nxt;
  logic            div_r, div_nxt;
  logic            neg_r, neg_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [63:0]     acc_r, acc_nxt;    // product or quotient
  logic [MW-1:0]   num_r, num_nxt;    // multiplier bits or dividend
  logic [63:0]     rem_r, rem_nxt;
  logic [31:0]     den_r, den_nxt;    // multiplicand or divisor
  logic            zero_r, zero_nxt;
  logic            done_r, done_nxt;
  logic signed [31:0] res_r, res_nxt;

  logic [31:0] ma, mb;
  logic [63:0] rsh, mres;
  logic [63:0] trial;

  always_comb begin
    ma = req.a[31] ? 32'(-req.a) : 32'(req.a);
    mb = req.b[31] ? 32'(-req.b) : 32'(req.b);
  end

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    rsh      = '0;
    mres     = '0;
    trial    = '0;
    if (!busy_r && req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      neg_nxt  = req.a[31] ^ req.b[31];
      acc_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = mb;
      zero_nxt = (mb == 32'd0);
      if (req.is_div) begin
        num_nxt = MW'(ma) << FRAC_BITS;
        cnt_nxt = CW'(MW);
        neg_nxt = (mb == 32'd0) ? req.a[31] : (req.a[31] ^ req.b[31]);
      end else begin
        num_nxt = MW'(ma);
        cnt_nxt = CW'(32);
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CW'(1);
        if (!div_r) begin
          // multiply: scan multiplier from MSB
          acc_nxt = (acc_r << 1) + (num_r[31] ? 64'(den_r) : 64'd0);
          num_nxt = num_r << 1;
        end else begin
          trial   = {rem_r[62:0], num_r[MW-1]};
          num_nxt = num_r << 1;
          if (trial >= 64'(den_r)) begin
            rem_nxt = trial - 64'(den_r);
            acc_nxt = {acc_r[62:0], 1'b1};
          end else begin
            rem_nxt = trial;
            acc_nxt = {acc_r[62:0], 1'b0};
          end
        end
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        rsh  = div_r ? acc_r : (acc_r >> FRAC_BITS);
        mres = (div_r && zero_r) ? 64'hFFFF_FFFF_FFFF_FFFF : rsh;
        if (neg_r) res_nxt = (mres >= 64'h8000_0000) ? SMIN : -$signed(32'(mres));
        else       res_nxt = (mres > 64'h7FFF_FFFF) ? SMAX : $signed(32'(mres));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ===== rtl/trapezoidal_velocity_step_core.sv =====
// Trapezoidal velocity step: one servo tick per transfer. Each item takes
// the remaining distance, updates the stored velocity by the trapezoidal
// rule and returns increment, new velocity and acceleration, all signed
// fixed point with FRAC_BITS fraction bits and saturated, plus the phase.
// All multiplies and divides go through one bit-serial unit (tvs_alu); a
// sequencer step holds the unit from request to result. An item needs five
// multiplies and two divides on the main path, one multiply fewer inside
// the final window, and one more multiply and one more divide when the
// last deceleration step is trimmed. An item inside the end window
// (epsilon) skips the arithmetic and goes straight to the output step.
// in_ready is high while the sequencer is idle; the result register holds
// one finished result, so the next item is worked on while it waits, and
// the input stalls only once a second result is ready behind it. Uses
// tvs_pkg and the defines header.
module trapezoidal_velocity_step_core #(
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tvs_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tvs_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tvs_pkg::*;
`include "trapezoidal_velocity_step_core_defines.svh"

  // configuration
  logic [30:0] final_vel_r, feed_cap_r, accel_r, cycle_r;
  logic [15:0] eps_r;

  // architectural state
  logic signed [31:0] vel_r, vel_nxt;
  logic [1:0]         phase_r, phase_nxt;

  seq_state_t st_r, st_nxt;

  // per-item working registers
  logic [30:0]        d_r, d_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [31:0] diff_r, diff_nxt;
  logic signed [31:0] ticks_r, ticks_nxt;
  logic signed [31:0] t0_r, t0_nxt;     // scratch: stop distance
  logic signed [31:0] win_r, win_nxt;   // end window
  logic signed [31:0] nv_r, nv_nxt;
  logic signed [31:0] inc_r, inc_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic               issued_r, issued_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  alu_req_t req;
  alu_rsp_t rsp;

  logic signed [31:0] fv_s, ac_s, cy_s, fc_s, d_s;
  logic signed [31:0] thr, dn, sum_nv;

  tvs_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
  );

  assign fv_s = $signed({1'b0, final_vel_r});
  assign ac_s = $signed({1'b0, accel_r});
  assign cy_s = $signed({1'b0, cycle_r});
  assign fc_s = $signed({1'b0, feed_cap_r});
  assign d_s  = $signed({1'b0, d_r});

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_vel_r <= '0;
      feed_cap_r  <= 31'd6553600;
      accel_r     <= 31'd65536;
      cycle_r     <= 31'd66;
      eps_r       <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FINAL_VEL: final_vel_r <= cfg_wdata;
        REG_FEED_CAP:  feed_cap_r  <= cfg_wdata;
        REG_ACCEL:     accel_r     <= cfg_wdata;
        REG_CYCLE:     cycle_r     <= cfg_wdata;
        REG_EPSILON:   eps_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (in_valid && in_ready) begin
                    st_nxt = ({1'b0, in_data.dist_left} < {16'd0, eps_r})
                             ? ST_OUT : ST_TICKS;
                  end
      ST_TICKS:   if (rsp.done) st_nxt = ST_M_DC;
      ST_M_DC:    if (rsp.done) st_nxt = ST_M_STOP;
      ST_M_STOP:  if (rsp.done) st_nxt = ST_M_WIN;
      ST_M_WIN:   if (rsp.done) st_nxt = ST_M_AC;
      ST_M_AC:    if (rsp.done) st_nxt = ST_DECIDE;
      ST_DECIDE:  begin
                    if (d_s < win_r) st_nxt = ST_ACC_OUT;
                    else if (d_s < thr) st_nxt = ST_DEC_INC;
                    else st_nxt = ST_ACC_INC;
                  end
      ST_DEC_INC: if (rsp.done) st_nxt = ST_DEC_CHK;
      ST_DEC_CHK: st_nxt = (inc_r >= d_s) ? ST_DEC_HV : ST_ACC_OUT;
      ST_DEC_HV:  if (rsp.done) st_nxt = ST_DEC_DIV;
      ST_DEC_DIV: if (rsp.done) st_nxt = ST_ACC_OUT;
      ST_ACC_INC: if (rsp.done) st_nxt = ST_ACC_OUT;
      ST_ACC_OUT: if (rsp.done) st_nxt = ST_OUT;
      // result register frees up this cycle if the pending result goes out
      ST_OUT:     if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // stop threshold: stop + half(accel * cycle), held in t0_r / inc_r
  assign thr    = sat33(33'(t0_r) + 33'(inc_r));
  assign dn     = sat33(33'(v_r) - 33'(ac_s));
  assign sum_nv = sat33(33'(nv_r) + 33'(v_r));

  // datapath and outputs
  always_comb begin
    d_nxt = d_r; v_nxt = v_r; diff_nxt = diff_r; ticks_nxt = ticks_r;
    t0_nxt = t0_r; win_nxt = win_r; nv_nxt = nv_r; inc_nxt = inc_r;
    acc_nxt = acc_r; ph_nxt = ph_r; vel_nxt = vel_r; phase_nxt = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    issued_nxt = issued_r;
    req = '0;
    if (rsp.done) issued_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          d_nxt    = in_data.dist_left;
          v_nxt    = in_data.new_move ? 32'sd0 : vel_r;
          vel_nxt  = v_nxt;
          diff_nxt = sat33(33'(v_nxt) - 33'(fv_s));
          nv_nxt   = v_nxt;
          inc_nxt  = '0;
          acc_nxt  = '0;
          ph_nxt   = PH_DONE;
        end
      end
      ST_TICKS: begin
        req = '{start: !issued_r, is_div: 1'b1, a: diff_r, b: ac_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) ticks_nxt = rsp.res;
      end
      ST_M_DC: begin
        req = '{start: !issued_r, is_div: 1'b0, a: diff_r, b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) t0_nxt = half32(rsp.res);
      end
      ST_M_STOP: begin
        req = '{start: !issued_r, is_div: 1'b0, a: t0_r, b: ticks_r};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) t0_nxt = rsp.res;
      end
      ST_M_WIN: begin
        req = '{start: !issued_r, is_div: 1'b0,
                a: half32(sat33(33'(fv_s) + 33'(ac_s))), b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) win_nxt = rsp.res;
      end
      ST_M_AC: begin
        req = '{start: !issued_r, is_div: 1'b0, a: ac_s, b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) inc_nxt = half32(rsp.res);
      end
      ST_DECIDE: begin
        if (d_s < win_r) begin
          ph_nxt = PH_DONE; nv_nxt = fv_s; inc_nxt = d_s;
        end else if (d_s < thr) begin
          ph_nxt = PH_DECEL;
          nv_nxt = (dn <= fv_s) ? fv_s : dn;
          if (nv_nxt < 0) nv_nxt = '0;
        end else begin
          ph_nxt = PH_ACCEL;
          nv_nxt = sat33(33'(v_r) + 33'(ac_s));
          if (nv_nxt > fc_s) begin
            nv_nxt = fc_s; ph_nxt = PH_CONST;
          end
        end
      end
      ST_DEC_INC: begin
        req = '{start: !issued_r, is_div: 1'b0, a: half32(sum_nv), b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) inc_nxt = rsp.res;
      end
      ST_DEC_CHK: ;
      ST_DEC_HV: begin
        req = '{start: !issued_r, is_div: 1'b0, a: half32(v_r), b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) t0_nxt = sat33(33'(d_s) - 33'(rsp.res));
      end
      ST_DEC_DIV: begin
        // 2 * rest, saturated
        req = '{start: !issued_r, is_div: 1'b1,
                a: sat33({t0_r, 1'b0}), b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) begin
          nv_nxt = rsp.res; inc_nxt = d_s;
        end
      end
      ST_ACC_INC: begin
        req = '{start: !issued_r, is_div: 1'b0,
                a: half32(sum_nv[31] ? ((sum_nv == SMIN) ? SMAX : -sum_nv) : sum_nv),
                b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) inc_nxt = rsp.res;
      end
      ST_ACC_OUT: begin
        req = '{start: !issued_r, is_div: 1'b1,
                a: sat33(33'(nv_r) - 33'(v_r)), b: cy_s};
        if (!issued_r) issued_nxt = 1'b1;
        if (rsp.done) begin
          acc_nxt = rsp.res;
          vel_nxt = nv_r;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{increment: inc_r, new_velocity: nv_r,
                      accel_out: acc_r, phase: ph_r};
          phase_nxt = ph_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      vel_r       <= '0;
      phase_r     <= PH_DONE;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vel_r       <= vel_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
    end
    d_r <= d_nxt; v_r <= v_nxt; diff_r <= diff_nxt; ticks_r <= ticks_nxt;
    t0_r <= t0_nxt; win_r <= win_nxt; nv_r <= nv_nxt; inc_r <= inc_nxt;
    acc_r <= acc_nxt; ph_r <= ph_nxt; out_r <= out_nxt;
  end

  // checks
  `TVS_ASSERT_IMP(a_ready_idle, in_ready, st_r == ST_IDLE, "ready outside idle")
  `TVS_ASSERT_NXT(a_out_once, (st_r == ST_OUT) && !out_valid_r, out_valid_r,
                  "result not presented")
  `TVS_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready,
                  out_valid_r && $stable(out_r), "waiting result changed")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for trapezoidal_velocity_step_core: drives servo ticks,
// predicts each result in fixed point and compares it. Depends on tvs_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import tvs_pkg::*;

  // run limit in cycles
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam longint Q_ONE = 65536;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  trapezoidal_velocity_step_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor copy of the registers and stored velocity
  longint fv_q, cap_q, acc_q, cyc_q, eps_q, vel_q;

  out_item_t tick_results_q[$];
  out_item_t exp_r;
  int mismatches;
  longint cycles;

  // sender burst shaping and receiver hold-off
  int burst_left;
  int hold_off_cycles;

  // ---------------------------------------------------------------------
  // Fixed-point helpers: exact product or quotient, truncated, saturated.
  // ---------------------------------------------------------------------
  function automatic longint sat(input longint x);
    if (x > S_MAX) return S_MAX;
    if (x < S_MIN) return S_MIN;
    return x;
  endfunction

  function automatic longint unsigned mag(input longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic longint sat_sign(input longint unsigned m, input bit neg);
    if (neg) return (m >= 64'd2147483648) ? S_MIN : -longint'(m);
    return (m > 64'd2147483647) ? S_MAX : longint'(m);
  endfunction

  function automatic longint qmul(input longint x, input longint y);
    longint unsigned p;
    p = (mag(x) * mag(y)) >> 16;
    return sat_sign(p, (x < 0) != (y < 0));
  endfunction

  function automatic longint qdiv(input longint x, input longint y);
    if (y == 0) return (x < 0) ? S_MIN : S_MAX;
    return sat_sign((mag(x) << 16) / mag(y), (x < 0) != (y < 0));
  endfunction

  // halving truncates toward zero
  function automatic longint halve(input longint x);
    return x / 2;
  endfunction

  // One servo tick of the trapezoidal rule; advances vel_q.
  function automatic out_item_t predict_tick(input in_item_t it);
    out_item_t r;
    longint d, v, nv, inc, acc, diff, ticks, stop, rest;
    logic [1:0] ph;
    d = it.dist_left;
    if (it.new_move) vel_q = 0;
    v = vel_q;
    if (d < eps_q) begin
      ph = PH_DONE;
      nv = v;
      inc = 0;
      acc = 0;
    end else begin
      diff = sat(v - fv_q);
      ticks = qdiv(diff, acc_q);
      stop = qmul(halve(qmul(diff, cyc_q)), ticks);
      if (d < qmul(halve(sat(fv_q + acc_q)), cyc_q)) begin
        // inside the final window: snap to final velocity
        ph = PH_DONE;
        nv = fv_q;
        inc = d;
      end else if (d < sat(stop + halve(qmul(acc_q, cyc_q)))) begin
        ph = PH_DECEL;
        nv = sat(v - acc_q);
        if (nv <= fv_q) nv = fv_q;
        if (nv < 0) nv = 0;
        inc = qmul(halve(sat(nv + v)), cyc_q);
        if (inc >= d) begin
          // overshoot: trim the last step to land exactly
          rest = sat(d - qmul(halve(v), cyc_q));
          nv = qdiv(sat(2 * rest), cyc_q);
          inc = d;
        end
      end else begin
        ph = PH_ACCEL;
        nv = sat(v + acc_q);
        if (nv > cap_q) begin
          nv = cap_q;
          ph = PH_CONST;
        end
        inc = qmul(halve(sat_sign(mag(sat(nv + v)), 1'b0)), cyc_q);
      end
      acc = qdiv(sat(nv - v), cyc_q);
      vel_q = nv;
    end
    r.increment = inc[31:0];
    r.new_velocity = nv[31:0];
    r.accel_out = acc[31:0];
    r.phase = ph;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------
  task automatic send_tick(input in_item_t it, output out_item_t res);
    int gap;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    res = predict_tick(it);
    tick_results_q = {tick_results_q, res};
    burst_left--;
  endtask

  task automatic send_dist(input longint d, input bit nm);
    in_item_t it;
    out_item_t r;
    it.dist_left = d[30:0];
    it.new_move = nm;
    send_tick(it, r);
  endtask

  // waits for every outstanding result, then lets the sequencer settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FINAL_VEL: fv_q = val & 64'h7FFF_FFFF;
      REG_FEED_CAP:  cap_q = val & 64'h7FFF_FFFF;
      REG_ACCEL:     acc_q = val & 64'h7FFF_FFFF;
      REG_CYCLE:     cyc_q = val & 64'h7FFF_FFFF;
      REG_EPSILON:   eps_q = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_profile(input longint fv, input longint cap, input longint acc,
                             input longint cyc, input longint eps);
    drain();
    write_reg(REG_FINAL_VEL, fv);
    write_reg(REG_FEED_CAP, cap);
    write_reg(REG_ACCEL, acc);
    write_reg(REG_CYCLE, cyc);
    write_reg(REG_EPSILON, eps);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: own stall pattern, plus the long hold-off when requested.
  // ---------------------------------------------------------------------
  int stall_mode;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result checker and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** trapezoidal_velocity_step_core: FAILED **");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_data);
      end else begin
        exp_r = tick_results_q.pop_front();
        if (out_data.increment !== exp_r.increment ||
            out_data.new_velocity !== exp_r.new_velocity ||
            out_data.accel_out !== exp_r.accel_out ||
            out_data.phase !== exp_r.phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: inc %0d/%0d vel %0d/%0d acc %0d/%0d ph %0d/%0d (exp/act)",
                     exp_r.increment, out_data.increment,
                     exp_r.new_velocity, out_data.new_velocity,
                     exp_r.accel_out, out_data.accel_out,
                     exp_r.phase, out_data.phase);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // extremes, end window, epsilon, reaching cruise, trimmed deceleration
  task automatic test_directed();
    send_dist(0, 1'b1);
    send_dist(6, 1'b0);                 // just under epsilon
    send_dist(7, 1'b0);                 // on epsilon: final window
    send_dist(64'h7FFF_FFFF, 1'b0);     // largest distance
    send_dist(64'h7FFF_FFFF, 1'b0);
    set_profile(0, 3 * Q_ONE, Q_ONE, 6553, 7);
    send_dist(64'h7FFF_FFFF, 1'b1);
    repeat (5) send_dist(64'h7FFF_FFFF, 1'b0);   // accelerate into cruise
    send_dist(Q_ONE / 4, 1'b0);                  // deceleration; the next tick trims the last step
    send_dist(Q_ONE / 8, 1'b0);
    send_dist(3, 1'b0);
    // register extremes
    set_profile(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 0);
    send_dist(0, 1'b1);
    send_dist(64'h7FFF_FFFF, 1'b0);
    send_dist(64'h4000_0000, 1'b0);
    send_dist(1, 1'b0);
    set_profile(0, 0, 1, 1, 16'hFFFF);
    send_dist(16'hFFFE, 1'b1);
    send_dist(16'hFFFF, 1'b0);
    send_dist(64'h7FFF_FFFF, 1'b0);
    send_dist(64'h7FFF_FFFF, 1'b1);
    set_profile(Q_ONE, 2 * Q_ONE, Q_ONE / 2, 32768, 0);
    send_dist(64'h7FFF_FFFF, 1'b1);
    send_dist(64'h7FFF_FFFF, 1'b0);
    send_dist(64'h7FFF_FFFF, 1'b0);
    send_dist(Q_ONE, 1'b0);
  endtask

  // well-formed moves: each tick sends the distance left after the last one
  task automatic test_moves(input int n_items);
    longint left_d, cap, cyc;
    out_item_t r;
    in_item_t it;
    int sent, ticks;
    sent = 0;
    while (sent < n_items) begin
      cap = $urandom_range(Q_ONE / 2, 200 * Q_ONE);
      case ($urandom_range(0, 3))
        0: cyc = 66;
        1: cyc = 655;
        2: cyc = 6553;
        default: cyc = $urandom_range(1, 2 * Q_ONE);
      endcase
      set_profile(($urandom_range(0, 2) == 0) ? $urandom_range(0, cap / 2) : 0, cap,
                  $urandom_range(Q_ONE / 16, 8 * Q_ONE), cyc, $urandom_range(0, 300));
      repeat ($urandom_range(2, 5)) begin
        left_d = sat(qmul(cap, cyc) * $urandom_range(2, 60));
        it.new_move = 1'b1;
        ticks = 0;
        do begin
          it.dist_left = left_d[30:0];
          send_tick(it, r);
          it.new_move = 1'b0;
          left_d = left_d - longint'(r.increment);
          if (left_d < 0) left_d = 0;
          ticks++;
          sent++;
        end while (r.phase != PH_DONE && ticks < 120 && sent < n_items);
      end
    end
  endtask

  // unstructured ticks across the full field ranges
  task automatic test_noise(input int n_items);
    longint d;
    repeat (4) begin
      set_profile($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                  $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF),
                  $urandom_range(0, 16'hFFFF));
      repeat (n_items / 4) begin
        case ($urandom_range(0, 2))
          0: d = $urandom_range(0, 32'h7FFF_FFFF);
          1: d = $urandom_range(0, 16'hFFFF);
          default: d = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
        endcase
        send_dist(d, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_back_pressure();
    set_profile(0, 50 * Q_ONE, Q_ONE, 655, 7);
    hold_off_cycles = 4000;
    send_dist(64'h7FFF_FFFF, 1'b1);
    repeat (11) send_dist(64'h7FFF_FFFF, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_ready = 1'b0;
    stall_mode = 0;
    hold_off_cycles = 0;
    burst_left = 0;
    mismatches = 0;
    cycles = 0;
    // reset values of the registers
    fv_q = 0;
    cap_q = 6553600;
    acc_q = 65536;
    cyc_q = 66;
    eps_q = 7;
    vel_q = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_back_pressure();
    test_moves(1500);
    test_noise(400);
    drain();

    if (mismatches == 0) begin
      $display("** trapezoidal_velocity_step_core: PASSED **");
    end else begin
      $display("** trapezoidal_velocity_step_core: FAILED **");
    end
    $finish;
  end

endmodule
